/* sv/sbat_pkg.sv */
package sbat_pkg;

  // field widths
  localparam int OP_W    = 2;
  localparam int REF_W   = 32;
  localparam int OFF_W   = 41;
  localparam int LEN_W   = 20;
  localparam int ST_W    = 3;
  localparam int PHYS_W  = 52;
  localparam int CIDX_W  = 2;
  localparam int CDATA_W = 48;
  localparam int SEC_W   = 32;
  localparam int CAR_W   = 48;
  localparam int CNT_W   = 11;

  // geometry constants
  localparam int HEADER_BYTES = 4096;
  localparam int TABLE_START  = 64;
  localparam int SECTOR_SHIFT = 9;
  localparam int TABLE_LIMIT  = (HEADER_BYTES - TABLE_START) / 4;

  // parameter defaults
  localparam int MAP_DEPTH_DEF  = 1024;
  localparam int MAX_CHUNKS_DEF = 64;

  typedef enum logic [OP_W-1:0] {
    OP_START = 2'd0,
    OP_ENTRY = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 3'd0,
    ST_BAD_GEO   = 3'd1,
    ST_RANGE     = 3'd2,
    ST_DUP       = 3'd3,
    ST_TRUNC     = 3'd4,
    ST_NOT_VALID = 3'd5
  } status_t;

  typedef enum logic [CIDX_W-1:0] {
    REG_SPB     = 2'd0,
    REG_MEDIA   = 2'd1,
    REG_CARRIER = 2'd2
  } reg_idx_t;

endpackage

/* sv/sbat_item_if.sv */
interface sbat_item_if import sbat_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [REF_W-1:0]  band_reference;
  logic [OFF_W-1:0]  read_offset;
  logic [LEN_W-1:0]  read_length;

  modport source(output valid, operation, band_reference, read_offset, read_length,
                 input ready);
  modport sink(input valid, operation, band_reference, read_offset, read_length,
               output ready);
endinterface

/* sv/sbat_result_if.sv */
interface sbat_result_if import sbat_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ST_W-1:0]   status;
  logic [PHYS_W-1:0] physical_offset;
  logic [LEN_W-1:0]  chunk_length;
  logic              zero_fill;
  logic [LEN_W-1:0]  total_bytes;
  logic              last;

  modport source(output valid, status, physical_offset, chunk_length, zero_fill,
                 total_bytes, last, input ready);
  modport sink(input valid, status, physical_offset, chunk_length, zero_fill,
               total_bytes, last, output ready);
endinterface

/* sv/sbat_cfg_if.sv */
interface sbat_cfg_if import sbat_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CIDX_W-1:0]  index;
  logic [CDATA_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

/* sv/sparse_band_address_translator.sv */
// start beat: walk the band map clean, divide media by sectors per band, then check the band
// count; table entry beat: map read, duplicate check, slot product and carrier check; read
// beat: offset divide, then S_RD_A, S_RD_B and S_RD_C per chunk beat; one beat in flight at
// a time, as items are taken only when idle; refused or empty beats give only a status beat
// rst (synchronous) clears control state, configuration registers and status to map not valid;
// the band map needs no clearing after reset since every start walks it clean
module sparse_band_address_translator import sbat_pkg::*; #(
  parameter int MAP_DEPTH  = MAP_DEPTH_DEF,
  parameter int MAX_CHUNKS = MAX_CHUNKS_DEF
) (
  input logic           clk,
  input logic           rst,
  sbat_item_if.sink     item,
  sbat_result_if.source result,
  sbat_cfg_if.sink      cfg
);

  localparam int AW  = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
  localparam int KW  = $clog2(MAX_CHUNKS + 1);
  localparam int DCW = $clog2(OFF_W);
  localparam int MW  = AW + OFF_W;

  typedef enum logic [3:0] {
    S_IDLE, S_CLR, S_DIV, S_GEO, S_ENT_RD, S_ENT_CHK, S_ENT_MUL, S_ENT_FIN,
    S_RD_A, S_RD_B, S_RD_C, S_DONE
  } state_t;

  state_t state;

  // configuration
  logic [SEC_W-1:0] spb, media;
  logic [CAR_W-1:0] carrier;

  // latched geometry and map state
  logic [SEC_W-1:0] gspb, gmedia;
  logic [CNT_W-1:0] bands, ecnt;
  logic [ST_W-1:0]  mstat, fin_st;

  // working registers
  logic [AW-1:0]     clr, phys, logi;
  logic [OFF_W-1:0]  off, inb, bleft, mleft;
  logic [LEN_W-1:0]  size, total, chunk;
  logic [KW-1:0]     k;
  logic [PHYS_W-1:0] prod, doff;
  logic              zf, div_rd;

  // shared divider
  logic [OFF_W-1:0] dq, dr, dd;
  logic [DCW-1:0]   dcnt;
  logic [OFF_W:0]   dsh, dsub;

  // band map
  logic [AW:0]   band_map [MAP_DEPTH];
  logic [AW:0]   mem_rd, mem_wd;
  logic [AW-1:0] mem_ra, mem_wa;
  logic          mem_we;

  // output register
  logic              rv, rlast, rzf;
  logic [ST_W-1:0]   rst_q;
  logic [PHYS_W-1:0] rphys;
  logic [LEN_W-1:0]  rlen, rtot;

  // combinational helpers
  logic [OFF_W-1:0]  bb, mb, req, reqc, c1;
  logic [AW-1:0]     mul_a;
  logic [MW-1:0]     mul_p;
  logic [PHYS_W:0]   need;
  logic [32:0]       nb;
  logic              slot_free, chunk_last, emit;
  logic [LEN_W-1:0]  chunk_next;

  assign bb        = {gspb, 9'b0};
  assign mb        = {gmedia, 9'b0};
  assign slot_free = !rv || result.ready;
  assign emit      = ((state == S_RD_C) || (state == S_DONE)) && slot_free;

  assign item.ready = (state == S_IDLE);
  assign cfg.ready  = 1'b1;

  assign result.valid           = rv;
  assign result.status          = rst_q;
  assign result.physical_offset = rphys;
  assign result.chunk_length    = rlen;
  assign result.zero_fill       = rzf;
  assign result.total_bytes     = rtot;
  assign result.last            = rlast;

  // divider step: shift in one dividend bit, subtract when it fits
  assign dsh  = {dr, dq[OFF_W-1]};
  assign dsub = dsh - {1'b0, dd};

  // shared multiplier, slot or band index times band bytes
  always_comb begin
    case (state)
      S_ENT_CHK: mul_a = phys;
      S_ENT_MUL: mul_a = logi;
      default:   mul_a = mem_rd[AW-1:0];
    endcase
    mul_p = mul_a * bb;
  end

  // geometry band count and entry truncation checks
  assign nb   = {1'b0, dq[31:0]} + {32'b0, (dr != '0)};
  assign req  = mb - prod[OFF_W-1:0];
  assign reqc = (req > bb) ? bb : req;
  assign need = {1'b0, doff} + {12'b0, reqc};

  // chunk size: band remainder, request remainder and media remainder
  always_comb begin
    c1 = (bleft < {21'b0, size}) ? bleft : {21'b0, size};
    c1 = (mleft < c1) ? mleft : c1;
    chunk_next = c1[LEN_W-1:0];
  end
  assign chunk_last = (size == chunk) || (mleft == {21'b0, chunk}) ||
                      (k == KW'(MAX_CHUNKS - 1));

  // band map port control
  always_comb begin
    mem_we = (state == S_CLR) || (state == S_ENT_CHK && !mem_rd[AW]);
    mem_wa = (state == S_CLR) ? clr : logi;
    mem_wd = (state == S_CLR) ? '0 : {1'b1, phys};
    mem_ra = (state == S_ENT_RD) ? logi : dq[AW-1:0];
  end

  // band map memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      band_map[mem_wa] <= mem_wd;
    end
    mem_rd <= band_map[mem_ra];
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      spb     <= '0;
      media   <= '0;
      carrier <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_SPB:     spb     <= cfg.data[SEC_W-1:0];
        REG_MEDIA:   media   <= cfg.data[SEC_W-1:0];
        REG_CARRIER: carrier <= cfg.data[CAR_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      gspb   <= '0;
      gmedia <= '0;
      bands  <= '0;
      ecnt   <= '0;
      mstat  <= ST_NOT_VALID;
      fin_st <= ST_OK;
      rv     <= 1'b0;
    end else begin
      if (result.ready && !emit) begin
        rv <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item.valid) begin
            case (item.operation)
              OP_START: begin
                gspb   <= spb;
                gmedia <= media;
                clr    <= '0;
                ecnt   <= '0;
                bands  <= '0;
                mstat  <= ST_BAD_GEO;
                state  <= S_CLR;
              end
              OP_ENTRY: begin
                if (mstat != ST_OK || ecnt >= bands) begin
                  fin_st <= mstat;
                  state  <= S_DONE;
                end else begin
                  phys <= ecnt[AW-1:0];
                  ecnt <= ecnt + 1'b1;
                  if (item.band_reference == '0) begin
                    fin_st <= mstat;
                    state  <= S_DONE;
                  end else if (item.band_reference > {21'b0, bands}) begin
                    mstat  <= ST_RANGE;
                    fin_st <= ST_RANGE;
                    state  <= S_DONE;
                  end else begin
                    fin_st <= mstat;
                    logi   <= AW'(item.band_reference - 32'd1);
                    state  <= S_ENT_RD;
                  end
                end
              end
              OP_READ: begin
                if (mstat != ST_OK || ecnt < bands || bands == '0) begin
                  fin_st <= ST_NOT_VALID;
                  state  <= S_DONE;
                end else if (item.read_length == '0 || item.read_offset >= mb) begin
                  fin_st <= ST_OK;
                  state  <= S_DONE;
                end else begin
                  off    <= item.read_offset;
                  size   <= item.read_length;
                  total  <= '0;
                  k      <= '0;
                  dq     <= item.read_offset;
                  dr     <= '0;
                  dd     <= bb;
                  dcnt   <= '0;
                  div_rd <= 1'b1;
                  state  <= S_DIV;
                end
              end
              default: ;
            endcase
          end
        end

        // walk the map clean, one entry a cycle
        S_CLR: begin
          if (clr == AW'(MAP_DEPTH - 1)) begin
            if (gspb == '0 || gmedia == '0) begin
              fin_st <= ST_BAD_GEO;
              state  <= S_DONE;
            end else begin
              dq     <= {9'b0, gmedia};
              dr     <= '0;
              dd     <= {9'b0, gspb};
              dcnt   <= '0;
              div_rd <= 1'b0;
              state  <= S_DIV;
            end
          end else begin
            clr <= clr + 1'b1;
          end
        end

        // one quotient bit per cycle
        S_DIV: begin
          if (!dsub[OFF_W]) begin
            dr <= dsub[OFF_W-1:0];
            dq <= {dq[OFF_W-2:0], 1'b1};
          end else begin
            dr <= dsh[OFF_W-1:0];
            dq <= {dq[OFF_W-2:0], 1'b0};
          end
          dcnt <= dcnt + 1'b1;
          if (dcnt == DCW'(OFF_W - 1)) begin
            state <= div_rd ? S_RD_A : S_GEO;
          end
        end

        S_GEO: begin
          if (nb <= 33'(TABLE_LIMIT) && nb <= 33'(MAP_DEPTH)) begin
            bands  <= nb[CNT_W-1:0];
            mstat  <= ST_OK;
            fin_st <= ST_OK;
          end else begin
            fin_st <= ST_BAD_GEO;
          end
          state <= S_DONE;
        end

        S_ENT_RD: state <= S_ENT_CHK;

        // duplicate check, record slot, start data offset product
        S_ENT_CHK: begin
          if (mem_rd[AW]) begin
            mstat  <= ST_DUP;
            fin_st <= ST_DUP;
            state  <= S_DONE;
          end else begin
            prod  <= PHYS_W'(mul_p);
            state <= S_ENT_MUL;
          end
        end

        S_ENT_MUL: begin
          doff  <= prod + PHYS_W'(HEADER_BYTES);
          prod  <= PHYS_W'(mul_p);
          state <= S_ENT_FIN;
        end

        // band data must fit in the carrier
        S_ENT_FIN: begin
          if (need > {1'b0, 4'b0, carrier}) begin
            mstat  <= ST_TRUNC;
            fin_st <= ST_TRUNC;
          end else begin
            fin_st <= mstat;
          end
          state <= S_DONE;
        end

        // after the divide, dq holds the band index and dr the in-band offset
        S_RD_A: begin
          if (k == '0) begin
            inb   <= dr;
            bleft <= bb - dr;
          end else begin
            bleft <= bb - inb;
          end
          mleft <= mb - off;
          state <= S_RD_B;
        end

        S_RD_B: begin
          prod  <= PHYS_W'(mul_p);
          zf    <= !mem_rd[AW];
          chunk <= chunk_next;
          state <= S_RD_C;
        end

        // emit one chunk beat and advance to the next band
        S_RD_C: begin
          if (slot_free) begin
            rv    <= 1'b1;
            rst_q <= ST_OK;
            rphys <= zf ? '0 : (prod + PHYS_W'(HEADER_BYTES) + {11'b0, inb});
            rlen  <= chunk;
            rzf   <= zf;
            rtot  <= total + chunk;
            rlast <= chunk_last;
            total <= total + chunk;
            off   <= off + {21'b0, chunk};
            size  <= size - chunk;
            inb   <= '0;
            dq    <= dq + 1'b1;
            k     <= k + 1'b1;
            state <= chunk_last ? S_IDLE : S_RD_A;
          end
        end

        // single status beat
        S_DONE: begin
          if (slot_free) begin
            rv    <= 1'b1;
            rst_q <= fin_st;
            rphys <= '0;
            rlen  <= '0;
            rzf   <= 1'b0;
            rtot  <= '0;
            rlast <= 1'b1;
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* tb/sv/tb_sparse_band_address_translator.sv */
`timescale 1ns / 1ps

module tb_sparse_band_address_translator;
  import sbat_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;

  typedef struct packed {
    op_t              operation;
    logic [REF_W-1:0] band_reference;
    logic [OFF_W-1:0] read_offset;
    logic [LEN_W-1:0] read_length;
  } request_t;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [PHYS_W-1:0] physical_offset;
    logic [LEN_W-1:0]  chunk_length;
    logic              zero_fill;
    logic [LEN_W-1:0]  total_bytes;
    logic              last;
  } chunk_cmd_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sbat_item_if   item_bus();
  sbat_result_if result_bus();
  sbat_cfg_if    cfg_bus();

  sparse_band_address_translator uut (
    .clk(clk), .rst(rst), .item(item_bus), .result(result_bus), .cfg(cfg_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // translator shadow state
  logic [10:0]        slot_map [1024];
  logic [31:0]        entries_seen;
  logic [ST_W-1:0]    table_status;
  logic [31:0]        spb_reg, media_reg;
  logic [47:0]        carrier_reg;
  logic [31:0]        lat_spb, lat_media, lat_bands;

  request_t   pending_items[$];
  chunk_cmd_t expected_chunks[$];
  int sender_idle_pct = 0;
  int receiver_idle_pct = 0;
  int error_count = 0;
  int items_sent = 0;
  int chunks_checked = 0;
  int reads_served = 0;
  longint cycle_count = 0;
  logic item_taken = 1'b0;

  function automatic chunk_cmd_t mk_cmd(logic [2:0] st, logic [51:0] ph, logic [19:0] len,
                                        logic zf, logic [19:0] tot, logic lst);
    chunk_cmd_t c;
    c.status = st; c.physical_offset = ph; c.chunk_length = len;
    c.zero_fill = zf; c.total_bytes = tot; c.last = lst;
    return c;
  endfunction

  // compute the chunk commands an accepted beat produces
  task automatic translate(request_t r);
    logic [31:0] nb, logical, phys;
    logic [63:0] band_b, media_b, data_off, req, off, sz, in_band, chunk, total, idx;
    logic [10:0] slot;
    int k;
    case (r.operation)
      OP_START: begin
        for (int i = 0; i < 1024; i++) slot_map[i] = '0;
        entries_seen = 0;
        lat_spb = spb_reg; lat_media = media_reg; lat_bands = 0;
        table_status = ST_BAD_GEO;
        if (lat_spb != 0 && lat_media != 0) begin
          nb = lat_media / lat_spb + ((lat_media % lat_spb) != 0 ? 1 : 0);
          if (nb <= TABLE_LIMIT && nb <= MAP_DEPTH_DEF) begin
            lat_bands = nb;
            table_status = ST_OK;
          end
        end
        expected_chunks.push_back(mk_cmd(table_status, 0, 0, 0, 0, 1));
      end
      OP_ENTRY: begin
        if (table_status == ST_OK && entries_seen < lat_bands) begin
          phys = entries_seen;
          entries_seen++;
          if (r.band_reference != 0) begin
            if (r.band_reference > lat_bands) table_status = ST_RANGE;
            else begin
              logical = r.band_reference - 1;
              if (slot_map[logical][10]) table_status = ST_DUP;
              else begin
                slot_map[logical] = {1'b1, phys[9:0]};
                band_b = 64'(lat_spb) * 512;
                media_b = 64'(lat_media) * 512;
                data_off = HEADER_BYTES + 64'(phys) * band_b;
                req = media_b - 64'(logical) * band_b;
                if (req > band_b) req = band_b;
                if (data_off > 64'(carrier_reg)) table_status = ST_TRUNC;
                else if (req > 64'(carrier_reg) - data_off) table_status = ST_TRUNC;
              end
            end
          end
        end
        expected_chunks.push_back(mk_cmd(table_status, 0, 0, 0, 0, 1));
      end
      OP_READ: begin
        if (table_status != ST_OK || entries_seen < lat_bands || lat_bands == 0) begin
          expected_chunks.push_back(mk_cmd(ST_NOT_VALID, 0, 0, 0, 0, 1));
        end else begin
          band_b = 64'(lat_spb) * 512;
          media_b = 64'(lat_media) * 512;
          off = 64'(r.read_offset); sz = 64'(r.read_length);
          total = 0; k = 0;
          while (sz != 0 && off < media_b && k < MAX_CHUNKS_DEF) begin
            in_band = off % band_b;
            chunk = band_b - in_band;
            if (chunk > sz) chunk = sz;
            if (chunk > media_b - off) chunk = media_b - off;
            idx = off / band_b;
            slot = (idx < 1024) ? slot_map[idx] : '0;
            total += chunk;
            if (slot[10])
              expected_chunks.push_back(mk_cmd(ST_OK,
                52'(HEADER_BYTES + 64'(slot[9:0]) * band_b + in_band),
                chunk[19:0], 0, total[19:0], 0));
            else
              expected_chunks.push_back(mk_cmd(ST_OK, 0, chunk[19:0], 1, total[19:0], 0));
            k++; off += chunk; sz -= chunk;
          end
          if (k == 0) expected_chunks.push_back(mk_cmd(ST_OK, 0, 0, 0, 0, 1));
          else begin
            expected_chunks[$].last = 1'b1;
            reads_served++;
          end
        end
      end
      default: ;
    endcase
  endtask

  // item driver
  always @(negedge clk) begin
    if (rst) begin
      item_bus.valid <= 1'b0;
    end else if (!item_bus.valid || item_taken) begin
      if (item_taken) items_sent++;
      if (pending_items.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
        request_t r;
        r = pending_items.pop_front();
        item_bus.valid          <= 1'b1;
        item_bus.operation      <= r.operation;
        item_bus.band_reference <= r.band_reference;
        item_bus.read_offset    <= r.read_offset;
        item_bus.read_length    <= r.read_length;
      end else begin
        item_bus.valid <= 1'b0;
      end
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    result_bus.ready <= rst ? 1'b0 : ($urandom_range(99) >= receiver_idle_pct);
  end

  // accepted beats feed the predictor; results are checked in order
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    item_taken = !rst && item_bus.valid && item_bus.ready;
    if (item_taken) begin
      request_t r;
      r.operation = op_t'(item_bus.operation);
      r.band_reference = item_bus.band_reference;
      r.read_offset = item_bus.read_offset;
      r.read_length = item_bus.read_length;
      translate(r);
    end
    if (!rst && cfg_bus.valid && cfg_bus.ready) begin
      case (reg_idx_t'(cfg_bus.index))
        REG_SPB:     spb_reg = cfg_bus.data[31:0];
        REG_MEDIA:   media_reg = cfg_bus.data[31:0];
        REG_CARRIER: carrier_reg = cfg_bus.data;
        default: ;
      endcase
    end
    if (!rst && result_bus.valid && result_bus.ready) begin
      if (expected_chunks.size() == 0) begin
        $error("unexpected result beat: status %0d", result_bus.status);
        error_count++;
      end else begin
        chunk_cmd_t e;
        e = expected_chunks.pop_front();
        chunks_checked++;
        if (result_bus.status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, result_bus.status); error_count++;
        end
        if (result_bus.physical_offset !== e.physical_offset) begin
          $error("physical_offset: expected %0h, got %0h", e.physical_offset,
                 result_bus.physical_offset); error_count++;
        end
        if (result_bus.chunk_length !== e.chunk_length) begin
          $error("chunk_length: expected %0d, got %0d", e.chunk_length,
                 result_bus.chunk_length); error_count++;
        end
        if (result_bus.zero_fill !== e.zero_fill) begin
          $error("zero_fill: expected %0d, got %0d", e.zero_fill, result_bus.zero_fill);
          error_count++;
        end
        if (result_bus.total_bytes !== e.total_bytes) begin
          $error("total_bytes: expected %0d, got %0d", e.total_bytes,
                 result_bus.total_bytes); error_count++;
        end
        if (result_bus.last !== e.last) begin
          $error("last: expected %0d, got %0d", e.last, result_bus.last); error_count++;
        end
      end
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", expected_chunks.size());
      $display("Verification failed");
      $finish;
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [47:0] value);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic set_geometry(logic [31:0] spb, logic [31:0] media, logic [47:0] car);
    write_reg(REG_SPB, spb);
    write_reg(REG_MEDIA, media);
    write_reg(REG_CARRIER, car);
  endtask

  task automatic push_item(op_t op, logic [31:0] ref_val, logic [40:0] off, logic [19:0] len);
    request_t r;
    r.operation = op; r.band_reference = ref_val; r.read_offset = off; r.read_length = len;
    pending_items.push_back(r);
  endtask

  // wait for all queued beats and their results, then let the block settle
  task automatic drain();
    while (pending_items.size() > 0 || item_bus.valid || expected_chunks.size() > 0)
      @(posedge clk);
    repeat (1200) @(posedge clk);
  endtask

  // table: a start beat, then a shuffled permutation of bands with holes at hole_pct percent
  task automatic build_table(int nb, int hole_pct);
    int perm[$];
    int j, t;
    for (int i = 0; i < nb; i++) perm.push_back(i + 1);
    for (int i = nb - 1; i > 0; i--) begin
      j = $urandom_range(i);
      t = perm[i]; perm[i] = perm[j]; perm[j] = t;
    end
    push_item(OP_START, $urandom, 41'($urandom), 20'($urandom));
    for (int i = 0; i < nb; i++)
      push_item(OP_ENTRY, ($urandom_range(99) < hole_pct) ? 0 : perm[i], 0, 0);
  endtask

  function automatic logic [40:0] rand_off(logic [40:0] media_b);
    case ($urandom_range(9))
      0: return 41'({$urandom, $urandom});
      1: return media_b - $urandom_range(64);
      default: return 41'({$urandom, $urandom} % (media_b + 64));
    endcase
  endfunction

  function automatic logic [19:0] rand_len();
    case ($urandom_range(5))
      0: return 20'($urandom);
      1: return 20'($urandom_range(3));
      default: return 20'($urandom_range(4096));
    endcase
  endfunction

  initial begin
    longint spb, media, nb;
    int budget, phase;
    item_bus.valid = 1'b0; item_bus.operation = '0; item_bus.band_reference = '0;
    item_bus.read_offset = '0; item_bus.read_length = '0;
    result_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0; cfg_bus.index = '0; cfg_bus.data = '0;
    spb_reg = 0; media_reg = 0; carrier_reg = 0;
    lat_spb = 0; lat_media = 0; lat_bands = 0;
    entries_seen = 0; table_status = ST_NOT_VALID;
    for (int i = 0; i < 1024; i++) slot_map[i] = '0;
    repeat (6) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // directed: reads and entries before any start, bad geometry, errors
    push_item(OP_READ, 0, 0, 100);
    push_item(OP_ENTRY, 1, 0, 0);
    push_item(OP_NONE, '1, '1, '1);
    drain();
    set_geometry(0, 100, 48'hFFFF_FFFF_FFFF);
    push_item(OP_START, 0, 0, 0);
    push_item(OP_ENTRY, 1, 0, 0);
    drain();
    set_geometry(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    push_item(OP_START, 0, 0, 0);
    drain();
    set_geometry(1, 1009, 48'hFFFF_FFFF_FFFF);
    push_item(OP_START, 0, 0, 0);
    drain();
    set_geometry(4, 10, 48'hFFFF_FFFF_FFFF);
    push_item(OP_START, 0, 0, 0);
    push_item(OP_ENTRY, 32'hFFFF_FFFF, 0, 0);
    push_item(OP_ENTRY, 1, 0, 0);
    push_item(OP_START, 0, 0, 0);
    push_item(OP_ENTRY, 2, 0, 0);
    push_item(OP_ENTRY, 2, 0, 0);
    push_item(OP_START, 0, 0, 0);
    push_item(OP_ENTRY, 3, 0, 0);
    push_item(OP_ENTRY, 0, 0, 0);
    push_item(OP_ENTRY, 1, 0, 0);
    push_item(OP_ENTRY, 2, 0, 0);
    push_item(OP_READ, 0, 0, 5120);
    push_item(OP_READ, 0, 41'h1FF_FFFF_FFFF, 20'hFFFFF);
    push_item(OP_READ, 0, 5119, 1);
    push_item(OP_READ, 0, 0, 0);
    drain();
    // truncated carrier, largest band count, then long reads over many bands
    set_geometry(4, 10, 4096 + 4000);
    build_table(3, 0);
    drain();
    set_geometry(1, 1008, 48'hFFFF_FFFF_FFFF);
    push_item(OP_START, 0, 0, 0);
    push_item(OP_READ, 0, 0, 100);
    drain();
    set_geometry(1, 80, 48'hFFFF_FFFF_FFFF);
    build_table(80, 20);
    push_item(OP_READ, 0, 0, 20'hFFFFF);
    push_item(OP_READ, 0, 300, 20'hFFFFF);
    drain();

    // random phases: receiver idles, sender idles, then neither
    for (phase = 0; phase < 3; phase++) begin
      sender_idle_pct = (phase == 0) ? 10 : (phase == 1) ? 56 : 0;
      receiver_idle_pct = (phase == 0) ? 56 : (phase == 1) ? 10 : 0;
      for (int s = 0; s < 4; s++) begin
        spb = ($urandom_range(3) == 0) ? $urandom_range(1, 2048) : $urandom_range(1, 8);
        media = spb * $urandom_range(1, 12) - $urandom_range(0, 32'(spb - 1));
        if (s == 3) spb = 32'hFFFF_FFFF;
        nb = (media + spb - 1) / spb;
        set_geometry(32'(spb), 32'(media), ($urandom_range(7) == 0) ?
                     48'(4096 + nb * spb * 512 - $urandom_range(1, 600))
                     : 48'hFFFF_FFFF_FFFF);
        if ($urandom_range(4) == 0) begin
          push_item(OP_START, 0, 0, 0);
          for (int i = 0; i < nb; i++)
            push_item(OP_ENTRY, $urandom_range(0, 32'(nb + 1)), 0, 0);
        end else build_table(int'(nb), 25);
        budget = 20;
        for (int i = 0; i < budget; i++) begin
          case ($urandom_range(19))
            0: push_item(OP_ENTRY, $urandom, 0, 0);
            1: push_item(OP_NONE, $urandom, 41'($urandom), 20'($urandom));
            default: push_item(OP_READ, $urandom, rand_off(41'(media * 512)), rand_len());
          endcase
        end
        drain();
      end
    end

    $display("covered %0d beats, %0d result beats checked, %0d reads served with chunks",
             items_sent, chunks_checked, reads_served);
    if (error_count == 0 && expected_chunks.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
